// ===== rtl/core/vlst_pkg.sv =====
// Package for the valve limit-switch tracker.
// Holds codes, widths and the structs shared by the interfaces and the modules.
// Depends on nothing.
package vlst_pkg;

	localparam int unsigned OVERSAMPLE_COUNT = 4;
	localparam int unsigned PHASE_W = (OVERSAMPLE_COUNT > 1) ? $clog2(OVERSAMPLE_COUNT) : 1;
	localparam logic [7:0] UNKNOWN_INDEX = 8'd255;
	localparam logic [OVERSAMPLE_COUNT-1:0] WIN_ALL_HIGH = '1;
	localparam logic [OVERSAMPLE_COUNT-1:0] WIN_ALL_LOW = '0;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_STEP = 3'd1;
	localparam logic [2:0] OP_MOVE_START = 3'd2;
	localparam logic [2:0] OP_MOVE_STOP = 3'd3;
	localparam logic [2:0] OP_BACKOFF = 3'd4;
	localparam logic [2:0] OP_RESET_POS = 3'd5;
	localparam logic [2:0] OP_INIT = 3'd6;

	localparam logic [1:0] MV_IDLE = 2'd0;
	localparam logic [1:0] MV_CLOSE = 2'd1;
	localparam logic [1:0] MV_OPEN = 2'd2;

	localparam logic [2:0] STUCK_NONE = 3'd0;
	localparam logic [2:0] STUCK_HARD_HIGH = 3'd1;
	localparam logic [2:0] STUCK_HARD_LOW = 3'd2;
	localparam logic [2:0] STUCK_SOFT = 3'd3;
	localparam logic [2:0] STUCK_BOUNCE = 3'd4;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_EDGE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_TICKS_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_TICKS_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SATURATION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULLY_OPEN_INDEX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_LIMIT = 3'd5;

	typedef struct packed {
		logic [7:0]  bounce_edge_limit;
		logic [15:0] stuck_ticks_high;
		logic [15:0] stuck_ticks_low;
		logic [15:0] tick_saturation;
		logic [7:0]  fully_open_index;
		logic [15:0] position_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] op;
		logic       pin_level;
		logic       direction;
		logic [7:0] restore_index;
		logic       full_cal;
	} item_t;

	typedef struct packed {
		logic        step_refused;
		logic [2:0]  stuck_code;
		logic [15:0] position;
		logic [7:0]  edge_position;
		logic        save_index;
		logic        calibrating;
	} result_t;

endpackage

// ===== rtl/core/vlst_if.sv =====
// Channel interfaces of the valve limit-switch tracker: items, results and register writes.
// Depends on vlst_pkg for the widths.
interface vlst_item_if import vlst_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic       pin_level;
	logic       direction;
	logic [7:0] restore_index;
	logic       full_cal;

	modport source (output valid, op, pin_level, direction, restore_index, full_cal,
		input ready);
	modport sink (input valid, op, pin_level, direction, restore_index, full_cal,
		output ready);
endinterface

interface vlst_result_if import vlst_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        step_refused;
	logic [2:0]  stuck_code;
	logic [15:0] position;
	logic [7:0]  edge_position;
	logic        save_index;
	logic        calibrating;

	modport source (output valid, step_refused, stuck_code, position, edge_position,
		save_index, calibrating, input ready);
	modport sink (input valid, step_refused, stuck_code, position, edge_position,
		save_index, calibrating, output ready);
endinterface

interface vlst_cfg_if import vlst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// ===== rtl/core/valve_limit_switch_tracker.sv =====
// Top level of the valve limit-switch tracker: input register, state update, result register.
// Depends on vlst_pkg, the channel interfaces, vlst_cfg_regs and vlst_core.
//
//   channel  | direction | content
//   item     | in        | op, pin_level, direction, restore_index, full_cal
//   result   | out       | step_refused, stuck_code, position, edge_position, save_index,
//            |           | calibrating
//   cfg      | in        | idx, data (register write, always ready)
//
// One item enters per cycle while the result is not stalled; each item passes through the
// input register and then the result register before its result can leave.
// The tracker state is updated in the cycle the item moves from the input register
// into the result register, so each item sees all earlier items.
// A stalled result holds both registers; the input stays ready while either is free.
// Reset clears all tracker state and loads the register defaults; no clearing pass.
module valve_limit_switch_tracker import vlst_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	vlst_item_if.sink   item,
	vlst_result_if.source result,
	vlst_cfg_if.sink    cfg
);

	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	vlst_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op <= item.op;
			item_s1.pin_level <= item.pin_level;
			item_s1.direction <= item.direction;
			item_s1.restore_index <= item.restore_index;
			item_s1.full_cal <= item.full_cal;
		end
		if (advance) res_s2 <= res_d;
	end

	vlst_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.regs  (regs),
		.update(advance),
		.itm   (item_s1),
		.res   (res_d)
	);

	assign result.valid = valid_s2;
	assign result.step_refused = res_s2.step_refused;
	assign result.stuck_code = res_s2.stuck_code;
	assign result.position = res_s2.position;
	assign result.edge_position = res_s2.edge_position;
	assign result.save_index = res_s2.save_index;
	assign result.calibrating = res_s2.calibrating;

	a_refused_means_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.step_refused) |-> (res_s2.stuck_code != STUCK_NONE))
		else $error("refused step reported with free valve");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> item.ready)
		else $error("input stalled while result register is empty");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item did not reach the result register");

endmodule

// ===== rtl/core/vlst_cfg_regs.sv =====
// Configuration register file of the valve limit-switch tracker.
// Depends on vlst_pkg and the vlst_cfg_if interface.
module vlst_cfg_regs import vlst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vlst_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bounce_edge_limit <= 8'd20;
			regs_q.stuck_ticks_high <= 16'd50;
			regs_q.stuck_ticks_low <= 16'd50;
			regs_q.tick_saturation <= 16'hFFFF;
			regs_q.fully_open_index <= 8'd10;
			regs_q.position_limit <= 16'hFFFF;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.idx)
				REG_BOUNCE_EDGE_LIMIT: regs_q.bounce_edge_limit <= cfg.data[7:0];
				REG_STUCK_TICKS_HIGH: regs_q.stuck_ticks_high <= cfg.data;
				REG_STUCK_TICKS_LOW: regs_q.stuck_ticks_low <= cfg.data;
				REG_TICK_SATURATION: regs_q.tick_saturation <= cfg.data;
				REG_FULLY_OPEN_INDEX: regs_q.fully_open_index <= cfg.data[7:0];
				REG_POSITION_LIMIT: regs_q.position_limit <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/vlst_core.sv =====
// Tracker state registers and the single-pass update for one item.
// Depends on vlst_pkg; driven by the pipeline registers of the top level.
module vlst_core import vlst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    regs,
	input  logic    update,
	input  item_t   itm,
	output result_t res
);

	logic [OVERSAMPLE_COUNT-1:0] window_q, window_d;
	logic [PHASE_W-1:0]          phase_q, phase_d;
	logic                        settled_q, settled_d;
	logic [1:0]                  move_q, move_d;
	logic [7:0]                  eidx_q, eidx_d;
	logic [7:0]                  edges_q, edges_d;
	logic [15:0]                 ticks_q, ticks_d;
	logic [2:0]                  stuck_q, stuck_d;
	logic                        backoff_q, backoff_d;
	logic                        fcal_q, fcal_d;
	logic [15:0]                 pos_q, pos_d;

	always_comb begin
		logic high;
		logic low;
		logic recal;
		logic save;
		logic refused;

		window_d = window_q;
		phase_d = phase_q;
		settled_d = settled_q;
		move_d = move_q;
		eidx_d = eidx_q;
		edges_d = edges_q;
		ticks_d = ticks_q;
		stuck_d = stuck_q;
		backoff_d = backoff_q;
		fcal_d = fcal_q;
		pos_d = pos_q;
		save = 1'b0;
		refused = 1'b0;
		high = 1'b0;
		low = 1'b0;
		recal = 1'b0;

		unique case (itm.op)
			OP_TICK: begin
				window_d[phase_q] = itm.pin_level;
				if (phase_q == PHASE_W'(OVERSAMPLE_COUNT - 1)) begin
					phase_d = '0;
				end else begin
					phase_d = phase_q + 1'b1;
				end
				if (phase_d == '0 && move_q != MV_IDLE) begin
					high = (window_d == WIN_ALL_HIGH);
					low = (window_d == WIN_ALL_LOW);
					if ((high && !settled_q) || (low && settled_q)) begin
						settled_d = high;
						if (move_q == MV_OPEN) begin
							eidx_d = eidx_q + 8'd1;
							if (edges_q != 8'hFF) edges_d = edges_q + 8'd1;
							save = 1'b1;
						end else if (move_q == MV_CLOSE && eidx_q != 8'd0) begin
							eidx_d = eidx_q - 8'd1;
							if (edges_q != 8'hFF) edges_d = edges_q + 8'd1;
							save = 1'b1;
						end
						ticks_d = '0;
					end
					if (ticks_d < regs.tick_saturation) ticks_d = ticks_d + 16'd1;
					recal = (stuck_q == STUCK_NONE) && (move_q == MV_CLOSE);
					if (edges_d > regs.bounce_edge_limit) begin
						if (recal) begin
							if (high) eidx_d = 8'd1;
							if (low) eidx_d = 8'd0;
							fcal_d = 1'b0;
							save = 1'b1;
						end
						stuck_d = STUCK_BOUNCE;
					end else if (high && ticks_d > regs.stuck_ticks_high) begin
						if (recal) begin
							eidx_d = 8'd1;
							fcal_d = 1'b0;
							save = 1'b1;
						end
						stuck_d = STUCK_HARD_HIGH;
					end else if (low && ticks_d > regs.stuck_ticks_low) begin
						if (recal) begin
							eidx_d = 8'd0;
							fcal_d = 1'b0;
							save = 1'b1;
						end
						stuck_d = STUCK_HARD_LOW;
					end else if (!fcal_q && eidx_d == 8'd0 && low) begin
						stuck_d = STUCK_SOFT;
					end else if (!fcal_q && eidx_d == 8'd1 && high) begin
						stuck_d = STUCK_SOFT;
					end else if (!fcal_q && backoff_q && eidx_d > 8'd1 &&
						eidx_d < regs.fully_open_index && low) begin
						stuck_d = STUCK_NONE;
						backoff_d = 1'b0;
					end
				end
			end
			OP_STEP: begin
				if (!backoff_q && stuck_q != STUCK_NONE) begin
					refused = 1'b1;
				end else if (move_q == MV_CLOSE && pos_q != 16'd0) begin
					pos_d = pos_q - 16'd1;
				end else if (move_q == MV_OPEN && pos_q < regs.position_limit) begin
					pos_d = pos_q + 16'd1;
				end
			end
			OP_MOVE_START: begin
				move_d = itm.direction ? MV_OPEN : MV_CLOSE;
				ticks_d = '0;
				edges_d = '0;
			end
			OP_MOVE_STOP: begin
				move_d = MV_IDLE;
				ticks_d = '0;
				edges_d = '0;
			end
			OP_BACKOFF: begin
				backoff_d = 1'b1;
			end
			OP_RESET_POS: begin
				pos_d = '0;
			end
			OP_INIT: begin
				eidx_d = itm.full_cal ? UNKNOWN_INDEX : itm.restore_index;
				if (itm.full_cal) save = 1'b1;
				if (eidx_d == UNKNOWN_INDEX) fcal_d = 1'b1;
			end
			default: begin
			end
		endcase

		res.step_refused = refused;
		res.stuck_code = stuck_d;
		res.position = pos_d;
		res.edge_position = eidx_d;
		res.save_index = save;
		res.calibrating = fcal_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			phase_q <= '0;
			settled_q <= 1'b0;
			move_q <= MV_IDLE;
			eidx_q <= UNKNOWN_INDEX;
			edges_q <= '0;
			ticks_q <= '0;
			stuck_q <= STUCK_NONE;
			backoff_q <= 1'b0;
			fcal_q <= 1'b0;
			pos_q <= '0;
		end else if (update) begin
			window_q <= window_d;
			phase_q <= phase_d;
			settled_q <= settled_d;
			move_q <= move_d;
			eidx_q <= eidx_d;
			edges_q <= edges_d;
			ticks_q <= ticks_d;
			stuck_q <= stuck_d;
			backoff_q <= backoff_d;
			fcal_q <= fcal_d;
			pos_q <= pos_d;
		end
	end

endmodule

// ===== tb/vlst_tracker_checker.sv =====
// Checker for the valve limit-switch tracker: watches the item, result and register write
// channels, predicts the result of every item transfer and compares it with the block.
// Depends on vlst_pkg and the channel interfaces.
module vlst_tracker_checker import vlst_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	vlst_item_if   item,
	vlst_result_if result,
	vlst_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t                        regs;
	logic [OVERSAMPLE_COUNT-1:0] window;
	logic [PHASE_W-1:0]          phase;
	logic                        settled;
	logic [1:0]                  motion;
	logic [7:0]                  edge_idx;
	logic [7:0]                  edge_cnt;
	logic [15:0]                 quiet_ticks;
	logic [2:0]                  stuck;
	logic                        backing_off;
	logic                        calib;
	logic [15:0]                 steps;
	logic                        save;

	result_t results_due[$];

	task automatic track_item(input item_t it, output result_t res);
		logic refused;
		logic all_high;
		logic all_low;
		logic recal;
		refused = 1'b0;
		save = 1'b0;
		case (it.op)
			OP_TICK: begin
				window[phase] = it.pin_level;
				phase = (phase == PHASE_W'(OVERSAMPLE_COUNT - 1)) ? '0 : phase + 1'b1;
				if (phase == '0 && motion != MV_IDLE) begin
					all_high = (window == WIN_ALL_HIGH);
					all_low = (window == WIN_ALL_LOW);
					if ((all_high && !settled) || (all_low && settled)) begin
						settled = all_high;
						if (motion == MV_OPEN) begin
							edge_idx = edge_idx + 8'd1;
							if (edge_cnt != 8'd255) edge_cnt = edge_cnt + 8'd1;
							save = 1'b1;
						end else if (motion == MV_CLOSE && edge_idx != 8'd0) begin
							edge_idx = edge_idx - 8'd1;
							if (edge_cnt != 8'd255) edge_cnt = edge_cnt + 8'd1;
							save = 1'b1;
						end
						quiet_ticks = '0;
					end
					if (quiet_ticks < regs.tick_saturation) quiet_ticks = quiet_ticks + 16'd1;
					recal = (stuck == STUCK_NONE) && (motion == MV_CLOSE);
					if (edge_cnt > regs.bounce_edge_limit) begin
						if (recal) begin
							if (all_high) edge_idx = 8'd1;
							if (all_low) edge_idx = 8'd0;
							calib = 1'b0;
							save = 1'b1;
						end
						stuck = STUCK_BOUNCE;
					end else if (all_high && quiet_ticks > regs.stuck_ticks_high) begin
						if (recal) begin
							edge_idx = 8'd1;
							calib = 1'b0;
							save = 1'b1;
						end
						stuck = STUCK_HARD_HIGH;
					end else if (all_low && quiet_ticks > regs.stuck_ticks_low) begin
						if (recal) begin
							edge_idx = 8'd0;
							calib = 1'b0;
							save = 1'b1;
						end
						stuck = STUCK_HARD_LOW;
					end else if (!calib && edge_idx == 8'd0 && all_low) begin
						stuck = STUCK_SOFT;
					end else if (!calib && edge_idx == 8'd1 && all_high) begin
						stuck = STUCK_SOFT;
					end else if (!calib && backing_off && edge_idx > 8'd1 &&
						edge_idx < regs.fully_open_index && all_low) begin
						stuck = STUCK_NONE;
						backing_off = 1'b0;
					end
				end
			end
			OP_STEP: begin
				if (!backing_off && stuck != STUCK_NONE) begin
					refused = 1'b1;
				end else if (motion == MV_CLOSE && steps != 16'd0) begin
					steps = steps - 16'd1;
				end else if (motion == MV_OPEN && steps < regs.position_limit) begin
					steps = steps + 16'd1;
				end
			end
			OP_MOVE_START: begin
				motion = it.direction ? MV_OPEN : MV_CLOSE;
				quiet_ticks = '0;
				edge_cnt = '0;
			end
			OP_MOVE_STOP: begin
				motion = MV_IDLE;
				quiet_ticks = '0;
				edge_cnt = '0;
			end
			OP_BACKOFF: begin
				backing_off = 1'b1;
			end
			OP_RESET_POS: begin
				steps = '0;
			end
			OP_INIT: begin
				edge_idx = it.restore_index;
				if (it.full_cal) begin
					edge_idx = UNKNOWN_INDEX;
					calib = 1'b1;
					save = 1'b1;
				end
				if (edge_idx == UNKNOWN_INDEX) calib = 1'b1;
			end
			default: begin
			end
		endcase
		res.step_refused = refused;
		res.stuck_code = stuck;
		res.position = steps;
		res.edge_position = edge_idx;
		res.save_index = save;
		res.calibrating = calib;
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		result_t got;
		if (!arst_n) begin
			regs.bounce_edge_limit = 8'd20;
			regs.stuck_ticks_high = 16'd50;
			regs.stuck_ticks_low = 16'd50;
			regs.tick_saturation = 16'hFFFF;
			regs.fully_open_index = 8'd10;
			regs.position_limit = 16'hFFFF;
			window = '0;
			phase = '0;
			settled = 1'b0;
			motion = MV_IDLE;
			edge_idx = UNKNOWN_INDEX;
			edge_cnt = '0;
			quiet_ticks = '0;
			stuck = STUCK_NONE;
			backing_off = 1'b0;
			calib = 1'b0;
			steps = '0;
			save = 1'b0;
			results_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_BOUNCE_EDGE_LIMIT: regs.bounce_edge_limit = cfg.data[7:0];
					REG_STUCK_TICKS_HIGH: regs.stuck_ticks_high = cfg.data;
					REG_STUCK_TICKS_LOW: regs.stuck_ticks_low = cfg.data;
					REG_TICK_SATURATION: regs.tick_saturation = cfg.data;
					REG_FULLY_OPEN_INDEX: regs.fully_open_index = cfg.data[7:0];
					REG_POSITION_LIMIT: regs.position_limit = cfg.data;
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				got.step_refused = result.step_refused;
				got.stuck_code = result.stuck_code;
				got.position = result.position;
				got.edge_position = result.edge_position;
				got.save_index = result.save_index;
				got.calibrating = result.calibrating;
				if (results_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with no item waiting for it", $realtime);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (got.step_refused !== want.step_refused ||
						got.stuck_code !== want.stuck_code ||
						got.position !== want.position ||
						got.edge_position !== want.edge_position ||
						got.save_index !== want.save_index ||
						got.calibrating !== want.calibrating) begin
						if (mismatches < 10) begin
							$display("%0t: expected refused=%0d code=%0d pos=%0d edge=%0d save=%0d cal=%0d",
								$realtime, want.step_refused, want.stuck_code, want.position,
								want.edge_position, want.save_index, want.calibrating);
							$display("%0t:   actual refused=%0d code=%0d pos=%0d edge=%0d save=%0d cal=%0d",
								$realtime, got.step_refused, got.stuck_code, got.position,
								got.edge_position, got.save_index, got.calibrating);
						end
						mismatches++;
					end
				end
			end
			if (item.valid && item.ready) begin
				it.op = item.op;
				it.pin_level = item.pin_level;
				it.direction = item.direction;
				it.restore_index = item.restore_index;
				it.full_cal = item.full_cal;
				track_item(it, want);
				results_due.push_back(want);
			end
			outstanding = results_due.size();
		end
	end

endmodule

// ===== tb/valve_limit_switch_tracker_tb.sv =====
// Top of the valve limit-switch tracker testbench: clock, reset, register settings and item
// stimulus, with random idling on both channels; the verdict comes from vlst_tracker_checker.
// Depends on vlst_pkg, the channel interfaces, the block and the checker.
module valve_limit_switch_tracker_tb import vlst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD = 10;
	localparam int PHASES = 6;
	localparam int ITEM_TARGET = 1750;
	localparam int LONG_MOVE_WINDOWS = 260;
	localparam int PHASE_TARGET =
		(ITEM_TARGET - LONG_MOVE_WINDOWS * int'(OVERSAMPLE_COUNT)) / (PHASES - 1);
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   tick_count;
	int   sent;
	int   cycles = 0;
	int   mismatches;
	int   outstanding;

	vlst_item_if   item_ch ();
	vlst_result_if result_ch ();
	vlst_cfg_if    cfg_ch ();

	valve_limit_switch_tracker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	vlst_tracker_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= steady || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** valve_limit_switch_tracker: FAILED **");
			$finish;
		end
	end

	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// The argument is the pin on a tick, the direction on a move start and
	// {full_cal, restore_index} on an init; every other field is random.
	task automatic send_item(input logic [2:0] op, input logic [8:0] arg);
		if ($urandom_range(299) == 0) wait_for_drain();
		while (!steady && $urandom_range(99) < 26) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.pin_level <= (op == OP_TICK) ? arg[0] : 1'($urandom);
		item_ch.direction <= (op == OP_MOVE_START) ? arg[0] : 1'($urandom);
		item_ch.restore_index <= (op == OP_INIT) ? arg[7:0] : 8'($urandom);
		item_ch.full_cal <= (op == OP_INIT) ? arg[8] : 1'($urandom);
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (op == OP_TICK) tick_count++;
		if (op != OP_UNUSED) sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_BOUNCE_EDGE_LIMIT, {8'd0, c.bounce_edge_limit});
		write_reg(REG_STUCK_TICKS_HIGH, c.stuck_ticks_high);
		write_reg(REG_STUCK_TICKS_LOW, c.stuck_ticks_low);
		write_reg(REG_TICK_SATURATION, c.tick_saturation);
		write_reg(REG_FULLY_OPEN_INDEX, {8'd0, c.fully_open_index});
		write_reg(REG_POSITION_LIMIT, c.position_limit);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_move();
		int   segs;
		int   len;
		logic level;
		bit   bouncy;
		if ($urandom_range(3) == 0)
			send_item(OP_INIT, {($urandom_range(7) == 0),
				8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12))});
		if ($urandom_range(2) == 0) send_item(OP_BACKOFF, '0);
		if ($urandom_range(9) == 0) send_item(OP_RESET_POS, '0);
		send_item(OP_MOVE_START, 9'($urandom_range(1)));
		level = 1'($urandom);
		bouncy = ($urandom_range(3) == 0);
		segs = bouncy ? $urandom_range(4, 14) : $urandom_range(1, 6);
		if ($urandom_range(4) != 0)
			while (tick_count % OVERSAMPLE_COUNT != 0) send_item(OP_TICK, 9'(level));
		repeat (segs) begin
			len = bouncy ? OVERSAMPLE_COUNT : OVERSAMPLE_COUNT * $urandom_range(1, 6);
			if ($urandom_range(9) == 0) len += $urandom_range(1, 3);
			repeat (len) begin
				send_item(OP_TICK, 9'(($urandom_range(19) == 0) ? !level : level));
				if ($urandom_range(99) < 30) send_item(OP_STEP, '0);
			end
			level = !level;
		end
		if ($urandom_range(9) != 0) send_item(OP_MOVE_STOP, '0);
	endtask

	initial begin
		cfg_t setting;
		arst_n <= 1'b0;
		steady = 1'b0;
		tick_count = 0;
		item_ch.valid <= 1'b0;
		item_ch.op <= OP_TICK;
		item_ch.pin_level <= 1'b0;
		item_ch.direction <= 1'b0;
		item_ch.restore_index <= '0;
		item_ch.full_cal <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.idx <= REG_BOUNCE_EDGE_LIMIT;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening at the unknown index wraps it to zero; idle ticks only fill the window.
		send_item(OP_UNUSED, 9'h1FF);
		send_item(OP_STEP, '0);
		repeat (OVERSAMPLE_COUNT) send_item(OP_TICK, 9'd1);
		send_item(OP_INIT, {1'b0, UNKNOWN_INDEX});
		send_item(OP_MOVE_START, 9'd1);
		repeat (OVERSAMPLE_COUNT) send_item(OP_TICK, 9'd1);
		send_item(OP_STEP, '0);
		send_item(OP_BACKOFF, '0);
		send_item(OP_MOVE_STOP, '0);
		send_item(OP_INIT, {1'b0, 8'd0});
		send_item(OP_INIT, {1'b1, 8'd0});
		send_item(OP_INIT, {1'b0, 8'd3});
		send_item(OP_MOVE_START, 9'd0);
		repeat (OVERSAMPLE_COUNT) send_item(OP_TICK, 9'd0);
		send_item(OP_STEP, '0);
		send_item(OP_STEP, '0);
		send_item(OP_RESET_POS, '0);
		send_item(OP_MOVE_STOP, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_for_drain();
				if (ph == 1) begin
					setting = '0;
				end else if (ph == 2) begin
					setting.bounce_edge_limit = 8'd254;
					setting.stuck_ticks_high = 16'hFFFF;
					setting.stuck_ticks_low = 16'hFFFF;
					setting.tick_saturation = 16'hFFFF;
					setting.fully_open_index = 8'd254;
					setting.position_limit = 16'hFFFF;
				end else begin
					setting.bounce_edge_limit = 8'($urandom_range(8));
					setting.stuck_ticks_high = 16'($urandom_range(6));
					setting.stuck_ticks_low = 16'($urandom_range(6));
					setting.tick_saturation = ($urandom_range(3) == 0) ? 16'hFFFF :
						16'($urandom_range(20));
					setting.fully_open_index = 8'($urandom_range(20));
					setting.position_limit = 16'($urandom_range(40));
				end
				program_regs(setting);
			end
			steady = (ph == 3);
			sent = 0;
			if (ph == 2) begin
				// Long opening move that drives the edge counter into saturation.
				while (tick_count % OVERSAMPLE_COUNT != 0) send_item(OP_TICK, '0);
				send_item(OP_MOVE_START, 9'd1);
				for (int n = 0; n < LONG_MOVE_WINDOWS * OVERSAMPLE_COUNT; n++)
					send_item(OP_TICK, 9'((n / OVERSAMPLE_COUNT + 1) % 2));
				send_item(OP_MOVE_STOP, '0);
			end
			while (sent < PHASE_TARGET) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(1, 8)) send_item(3'($urandom), 9'($urandom));
				end else begin
					run_move();
				end
			end
		end

		wait_for_drain();
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** valve_limit_switch_tracker: PASSED **");
		end else begin
			$display("** valve_limit_switch_tracker: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/vlst_pkg.sv
rtl/core/vlst_if.sv
rtl/core/vlst_cfg_regs.sv
rtl/core/vlst_core.sv
rtl/core/valve_limit_switch_tracker.sv
tb/vlst_tracker_checker.sv
tb/valve_limit_switch_tracker_tb.sv
